// ===== src/aadr_pkg.sv =====
// aadr_pkg: shared types, constants and tables for the axis-angle direction rotator
// used by aadr_ctrl, aadr_dp and the top level under src; depends on nothing
package aadr_pkg;

  localparam int COMPONENT_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int TRIG_BITS          = 30;
  localparam int ANG_W              = 34;
  localparam int STEP_W             = 5;
  localparam int N_OPS              = 19;
  localparam int REQ_LOAD           = 1;

  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] HALF_TURN = 34'sd2147483648;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE, ST_SINCOS, ST_PROD, ST_ATAN, ST_DONE
  } aadr_state_t;

  // products in the order the shared multiplier takes them
  typedef enum logic [STEP_W-1:0] {
    OP_DOT0, OP_DOT1, OP_DOT2,
    OP_CR0A, OP_CR0B, OP_CR1A, OP_CR1B, OP_CR2A, OP_CR2B,
    OP_T,
    OP_NV0C, OP_NV0S, OP_NV0K,
    OP_NV1C, OP_NV1S, OP_NV1K,
    OP_NV2C, OP_NV2S, OP_NV2K
  } aadr_op_t;

  // controller commands to the datapath
  typedef struct packed {
    logic       capture;
    logic       sc_step;
    logic       mul_step;
    logic       at_init;
    logic       at_step;
    logic       commit;
    logic [STEP_W-1:0] step_idx;
  } aadr_cmd_t;

  // status back from the datapath
  typedef struct packed {
    logic is_load;
  } aadr_sts_t;

  // atan(2^-i), 2^32 units per turn
  function automatic logic [31:0] atan_step(input logic [STEP_W-1:0] i);
    logic [31:0] r;
    unique case (i)
      5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E; 5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4; 5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55; 5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/aadr_ctrl.sv =====
// aadr_ctrl: sequencer for sincos, product and atan2 phases
// depends on aadr_pkg
module aadr_ctrl #(
  parameter int CORDIC_STEPS = aadr_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  aadr_pkg::aadr_sts_t sts,
  output aadr_pkg::aadr_cmd_t cmd
);

  aadr_pkg::aadr_state_t state_r, state_nxt;
  logic [aadr_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != aadr_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      aadr_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) state_nxt = aadr_pkg::ST_SINCOS;
      end
      aadr_pkg::ST_SINCOS: begin
        if (sts.is_load) begin
          state_nxt = aadr_pkg::ST_ATAN;
          cnt_nxt = '0;
        end else if (cnt_r == aadr_pkg::STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = aadr_pkg::ST_PROD;
          cnt_nxt = '0;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      aadr_pkg::ST_PROD: begin
        // an extra step after the last product drains the last registered product
        if (cnt_r == aadr_pkg::STEP_W'(aadr_pkg::N_OPS)) begin
          state_nxt = aadr_pkg::ST_ATAN;
          cnt_nxt = '0;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      aadr_pkg::ST_ATAN: begin
        if (cnt_r == aadr_pkg::STEP_W'(CORDIC_STEPS)) begin
          state_nxt = aadr_pkg::ST_DONE;
        end else cnt_nxt = cnt_r + 1'b1;
      end
      aadr_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = aadr_pkg::ST_IDLE;
      end
      default: state_nxt = aadr_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.step_idx = cnt_r;
    unique case (state_r)
      aadr_pkg::ST_IDLE:   cmd.capture = accept;
      aadr_pkg::ST_SINCOS: cmd.sc_step = !sts.is_load;
      aadr_pkg::ST_PROD:   cmd.mul_step = (cnt_r < aadr_pkg::STEP_W'(aadr_pkg::N_OPS));
      aadr_pkg::ST_ATAN: begin
        cmd.at_init = (cnt_r == '0);
        cmd.at_step = (cnt_r != '0);
        cmd.step_idx = cnt_r - 1'b1;
      end
      aadr_pkg::ST_DONE:   cmd.commit = (!out_valid_r || !out_stall);
      default: ;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aadr_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/aadr_dp.sv =====
// aadr_dp: direction register, shared cordic unit and shared multiplier
// depends on aadr_pkg
module aadr_dp #(
  parameter int COMPONENT_BITS = aadr_pkg::COMPONENT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_req_type,
  input  logic signed [15:0]         in_turn_angle,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_x,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_y,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_z,
  input  aadr_pkg::aadr_cmd_t        cmd,
  output aadr_pkg::aadr_sts_t        sts,
  output logic signed [COMPONENT_BITS-1:0] out_dir_x,
  output logic signed [COMPONENT_BITS-1:0] out_dir_y,
  output logic signed [COMPONENT_BITS-1:0] out_dir_z,
  output logic [15:0]                out_heading,
  output logic                       out_heading_undefined
);

  localparam int CW   = COMPONENT_BITS;
  localparam int FB   = CW - 2;
  localparam int TB   = aadr_pkg::TRIG_BITS;
  localparam int AW   = aadr_pkg::ANG_W;
  localparam int MW   = CW + 34;            // product width
  localparam int PW   = CW + 35;            // accumulator width
  localparam int SW   = 36;                 // cordic register width
  localparam int SH   = 32 - CW;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] UNIT = CW'(1) <<< FB;
  localparam logic signed [PW-1:0] HALF_FB = PW'(1) <<< (FB - 1);
  localparam logic signed [PW-1:0] HALF_TB = PW'(1) <<< (TB - 1);

  // saturate a wide sum into the component range
  function automatic logic signed [CW-1:0] sat(input logic signed [PW-1:0] v);
    if (v > PW'(CMAX)) return CMAX;
    if (v < PW'(CMIN)) return CMIN;
    return v[CW-1:0];
  endfunction

  logic signed [CW-1:0] v_r [3];
  logic signed [CW-1:0] k_r [3];
  logic signed [CW-1:0] nv_r [3];
  logic is_load_r;
  logic sc_neg_r;
  logic signed [SW-1:0] cx_r, cy_r;
  logic signed [AW-1:0] cz_r;
  logic signed [CW-1:0] dot_r, t_r;
  logic signed [CW-1:0] cr_r [3];
  logic signed [PW-1:0] acc_r, pr_r;
  aadr_pkg::aadr_op_t pop_r;
  logic pv_r;

  logic signed [16:0] a17;
  logic sc_neg;
  logic signed [SW-1:0] sdx, sdy, nx, ny;
  logic signed [AW-1:0] nz, at;
  logic up;
  logic signed [33:0] c_v, s_v, omc_v;
  aadr_pkg::aadr_op_t op;
  logic signed [CW-1:0] ma;
  logic signed [33:0]   mb;
  logic signed [MW-1:0] prod;
  logic use_tb;
  logic signed [PW-1:0] rp;
  logic signed [SW-1:0] ax0, ay0, xs, ys;
  logic signed [AW-1:0] az0;
  logic [AW-1:0] hz;
  logic [15:0] hd;
  logic xy_zero;

  // sine/cosine start: fold angle into half turn
  always_comb begin
    a17 = 17'(in_turn_angle);
    sc_neg = 1'b0;
    if (a17 > 17'sd16384) begin
      a17 = a17 - 17'sd32768;
      sc_neg = 1'b1;
    end
    if (a17 < -17'sd16384) begin
      a17 = a17 + 17'sd32768;
      sc_neg = 1'b1;
    end
  end

  // one shared cordic stage: rotation drives z to zero, vectoring drives y to zero
  always_comb begin
    sdx = cy_r >>> cmd.step_idx;
    sdy = cx_r >>> cmd.step_idx;
    at  = AW'(aadr_pkg::atan_step(cmd.step_idx));
    up  = cmd.at_step ? (cy_r >= 0) : (cz_r < 0);
    if (up) begin
      nx = cx_r + sdx; ny = cy_r - sdy; nz = cz_r + at;
    end else begin
      nx = cx_r - sdx; ny = cy_r + sdy; nz = cz_r - at;
    end
  end

  // cosine, sine and one minus cosine with the fold undone
  assign c_v   = sc_neg_r ? -34'(cx_r) : 34'(cx_r);
  assign s_v   = sc_neg_r ? -34'(cy_r) : 34'(cy_r);
  assign omc_v = (34'sd1 <<< TB) - c_v;

  // shared multiplier: operand select per product
  assign op = aadr_pkg::aadr_op_t'(cmd.step_idx);
  always_comb begin
    ma = '0; mb = '0;
    if (cmd.mul_step) begin
      unique case (op)
        aadr_pkg::OP_DOT0: begin ma = k_r[0];  mb = 34'(v_r[0]); end
        aadr_pkg::OP_DOT1: begin ma = k_r[1];  mb = 34'(v_r[1]); end
        aadr_pkg::OP_DOT2: begin ma = k_r[2];  mb = 34'(v_r[2]); end
        aadr_pkg::OP_CR0A: begin ma = k_r[1];  mb = 34'(v_r[2]); end
        aadr_pkg::OP_CR0B: begin ma = k_r[2];  mb = 34'(v_r[1]); end
        aadr_pkg::OP_CR1A: begin ma = k_r[2];  mb = 34'(v_r[0]); end
        aadr_pkg::OP_CR1B: begin ma = k_r[0];  mb = 34'(v_r[2]); end
        aadr_pkg::OP_CR2A: begin ma = k_r[0];  mb = 34'(v_r[1]); end
        aadr_pkg::OP_CR2B: begin ma = k_r[1];  mb = 34'(v_r[0]); end
        aadr_pkg::OP_T:    begin ma = dot_r;   mb = omc_v;       end
        aadr_pkg::OP_NV0C: begin ma = v_r[0];  mb = c_v;         end
        aadr_pkg::OP_NV0S: begin ma = cr_r[0]; mb = s_v;         end
        aadr_pkg::OP_NV0K: begin ma = k_r[0];  mb = 34'(t_r);    end
        aadr_pkg::OP_NV1C: begin ma = v_r[1];  mb = c_v;         end
        aadr_pkg::OP_NV1S: begin ma = cr_r[1]; mb = s_v;         end
        aadr_pkg::OP_NV1K: begin ma = k_r[1];  mb = 34'(t_r);    end
        aadr_pkg::OP_NV2C: begin ma = v_r[2];  mb = c_v;         end
        aadr_pkg::OP_NV2S: begin ma = cr_r[2]; mb = s_v;         end
        aadr_pkg::OP_NV2K: begin ma = k_r[2];  mb = 34'(t_r);    end
        default: ;
      endcase
    end
    prod = ma * mb;
  end

  // rounding of the registered product, trig terms carry 30 fraction bits
  assign use_tb = pop_r inside {aadr_pkg::OP_T, aadr_pkg::OP_NV0C, aadr_pkg::OP_NV0S,
                                aadr_pkg::OP_NV1C, aadr_pkg::OP_NV1S,
                                aadr_pkg::OP_NV2C, aadr_pkg::OP_NV2S};
  assign rp = use_tb ? ((pr_r + HALF_TB) >>> TB) : ((pr_r + HALF_FB) >>> FB);

  // atan2 start: scale to 32 bits, fold left half plane
  always_comb begin
    xs = SW'(nv_r[1]) <<< SH;
    ys = -(SW'(nv_r[0]) <<< SH);
    ax0 = xs; ay0 = ys; az0 = '0;
    if (xs < 0) begin
      ax0 = -xs; ay0 = -ys; az0 = aadr_pkg::HALF_TURN;
    end
  end

  // heading rounded to 65536 units per turn
  assign hz = $unsigned(cz_r) + AW'(32768);
  assign hd = hz[31:16];
  assign xy_zero = (nv_r[0] == '0) && (nv_r[1] == '0);

  assign sts.is_load = is_load_r;

  // held direction and product pipeline valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= '0;
      v_r[1] <= UNIT;
      v_r[2] <= '0;
      pv_r   <= 1'b0;
    end else begin
      if (cmd.commit) v_r <= nv_r;
      pv_r <= cmd.mul_step;
    end
  end

  // phase registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      is_load_r <= (in_req_type == 1'(aadr_pkg::REQ_LOAD));
      sc_neg_r  <= sc_neg;
      k_r[0] <= in_vec_x; k_r[1] <= in_vec_y; k_r[2] <= in_vec_z;
      nv_r[0] <= in_vec_x; nv_r[1] <= in_vec_y; nv_r[2] <= in_vec_z;
    end
    // cordic registers
    if (cmd.capture) begin
      cx_r <= SW'(aadr_pkg::CORDIC_GAIN);
      cy_r <= '0;
      cz_r <= AW'(a17) <<< 16;
    end else if (cmd.at_init) begin
      cx_r <= ax0; cy_r <= ay0; cz_r <= az0;
    end else if (cmd.sc_step || cmd.at_step) begin
      cx_r <= nx; cy_r <= ny; cz_r <= nz;
    end
    // multiplier output register
    if (cmd.mul_step) begin
      pr_r  <= PW'(prod);
      pop_r <= op;
    end
    // dot, cross, t and the new components from rounded products
    if (pv_r) begin
      case (pop_r) inside
        aadr_pkg::OP_DOT0, aadr_pkg::OP_CR0A, aadr_pkg::OP_CR1A, aadr_pkg::OP_CR2A,
        aadr_pkg::OP_NV0C, aadr_pkg::OP_NV1C, aadr_pkg::OP_NV2C: acc_r <= rp;
        aadr_pkg::OP_DOT1, aadr_pkg::OP_NV0S, aadr_pkg::OP_NV1S,
        aadr_pkg::OP_NV2S: acc_r <= acc_r + rp;
        aadr_pkg::OP_DOT2: dot_r <= sat(acc_r + rp);
        aadr_pkg::OP_CR0B: cr_r[0] <= sat(acc_r - rp);
        aadr_pkg::OP_CR1B: cr_r[1] <= sat(acc_r - rp);
        aadr_pkg::OP_CR2B: cr_r[2] <= sat(acc_r - rp);
        aadr_pkg::OP_T:    t_r <= sat(rp);
        aadr_pkg::OP_NV0K: nv_r[0] <= sat(acc_r + rp);
        aadr_pkg::OP_NV1K: nv_r[1] <= sat(acc_r + rp);
        aadr_pkg::OP_NV2K: nv_r[2] <= sat(acc_r + rp);
        default: ;
      endcase
    end
    // result register
    if (cmd.commit) begin
      out_dir_x <= nv_r[0]; out_dir_y <= nv_r[1]; out_dir_z <= nv_r[2];
      out_heading <= xy_zero ? 16'd0 : hd;
      out_heading_undefined <= xy_zero;
    end
  end

endmodule

// ===== src/axis_angle_direction_rotator.sv =====
// axis_angle_direction_rotator: top level, controller plus datapath
// depends on aadr_pkg, aadr_ctrl, aadr_dp
//
//  channel | beat contents                                   | handshake
//  in      | req_type, turn_angle, vec_x, vec_y, vec_z       | in_valid / in_stall
//  out     | dir_x, dir_y, dir_z, heading, heading_undefined | out_valid / out_stall
//
// a rotate beat: accept, the sincos phase, the product phase (19 products through one
// registered multiplier plus a drain), the atan2 phase, then one commit
// a load beat skips sincos and products: accept, atan2 of the loaded direction, commit
// one shared cordic stage serves sincos and atan2, one shared multiplier every product
// reset returns the direction to (0, 1.0, 0); in_stall stays high while busy
// a result held by out_stall delays the next commit, not the next accept
module axis_angle_direction_rotator #(
  parameter int COMPONENT_BITS = aadr_pkg::COMPONENT_BITS_DEF,
  parameter int CORDIC_STEPS   = aadr_pkg::CORDIC_STEPS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_req_type,
  input  logic signed [15:0] in_turn_angle,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_x,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_y,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_z,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [COMPONENT_BITS-1:0] out_dir_x,
  output logic signed [COMPONENT_BITS-1:0] out_dir_y,
  output logic signed [COMPONENT_BITS-1:0] out_dir_z,
  output logic [15:0] out_heading,
  output logic out_heading_undefined
);

  aadr_pkg::aadr_cmd_t cmd;
  aadr_pkg::aadr_sts_t sts;

  aadr_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  aadr_dp #(.COMPONENT_BITS(COMPONENT_BITS)) u_dp (
    .clk, .rst_n, .in_req_type, .in_turn_angle, .in_vec_x, .in_vec_y, .in_vec_z,
    .cmd, .sts, .out_dir_x, .out_dir_y, .out_dir_z, .out_heading,
    .out_heading_undefined
  );

endmodule

// ===== src/aadr_checker.sv =====
// aadr_checker: port-level checks on the rotator
// depends on axis_angle_direction_rotator ports; bound below
module aadr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [15:0] out_heading,
  input logic out_heading_undefined
);

  // held beat keeps its valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("out beat dropped");

  // undefined heading reads zero
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_heading_undefined |-> out_heading == 16'd0)
    else $error("undefined heading not zero");

  // an accepted beat makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("not busy after accept");

  // result cannot appear the cycle after accept
  a_no_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result too early");

endmodule

bind axis_angle_direction_rotator aadr_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_heading, .out_heading_undefined
);
